### src/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// Shared constants for the sender resistance linearizer: field widths,
// breakpoint tables, segment divisors and their fixed-point reciprocals.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int FRAC_BITS = 8;

  localparam int CMD_W   = 1;
  localparam int OHMS_W  = 12;
  localparam int VALUE_W = 16;

  localparam int PRESS_POINTS = 11;
  localparam int TEMP_POINTS  = 6;

  localparam int SEG_W  = 4;
  localparam int TSEG_W = 3;
  localparam int OFF_W  = 9;
  localparam int SPAN_W = 5;
  localparam int DIV_W  = 9;
  localparam int DEG_W  = 8;

  localparam int BASE_W  = DEG_W + FRAC_BITS;
  localparam int NUM_W   = OFF_W + SPAN_W + FRAC_BITS;
  localparam int RECIP_W = NUM_W - 3;
  localparam int Q_W     = SPAN_W + FRAC_BITS;
  localparam int QD_W    = Q_W + DIV_W;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int EXT_W   = BASE_W + VALUE_W;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  localparam logic [63:0] RECIP_ONE = 64'(1) << NUM_W;

  localparam logic [CMD_W-1:0] CMD_PRESSURE    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TEMPERATURE = 1'b1;

  localparam logic [OHMS_W-1:0] PRESS_OHM [PRESS_POINTS] = '{
    12'd6, 12'd23, 12'd39, 12'd54, 12'd69, 12'd89, 12'd106, 12'd121, 12'd140,
    12'd150, 12'd160
  };

  localparam logic [DEG_W-1:0] TEMP_DEG [TEMP_POINTS] = '{
    8'd50, 8'd70, 8'd80, 8'd95, 8'd120, 8'd150
  };

  localparam logic [OHMS_W-1:0] TEMP_OHM [TEMP_POINTS] = '{
    12'd680, 12'd310, 12'd230, 12'd140, 12'd75, 12'd40
  };

  localparam logic [DIV_W-1:0] PRESS_DIV [PRESS_POINTS-1] = '{
    9'd17, 9'd16, 9'd15, 9'd15, 9'd20, 9'd17, 9'd15, 9'd19, 9'd10, 9'd10
  };

  localparam logic [DIV_W-1:0] TEMP_DIV [TEMP_POINTS-1] = '{
    9'd370, 9'd80, 9'd90, 9'd65, 9'd35
  };

  // Reciprocals are rounded down, so a quotient estimate is never high and
  // is at most one below the true quotient.
  localparam logic [RECIP_W-1:0] PRESS_RECIP [PRESS_POINTS-1] = '{
    RECIP_W'(RECIP_ONE / 64'd17), RECIP_W'(RECIP_ONE / 64'd16),
    RECIP_W'(RECIP_ONE / 64'd15), RECIP_W'(RECIP_ONE / 64'd15),
    RECIP_W'(RECIP_ONE / 64'd20), RECIP_W'(RECIP_ONE / 64'd17),
    RECIP_W'(RECIP_ONE / 64'd15), RECIP_W'(RECIP_ONE / 64'd19),
    RECIP_W'(RECIP_ONE / 64'd10), RECIP_W'(RECIP_ONE / 64'd10)
  };

  localparam logic [RECIP_W-1:0] TEMP_RECIP [TEMP_POINTS-1] = '{
    RECIP_W'(RECIP_ONE / 64'd370), RECIP_W'(RECIP_ONE / 64'd80),
    RECIP_W'(RECIP_ONE / 64'd90), RECIP_W'(RECIP_ONE / 64'd65),
    RECIP_W'(RECIP_ONE / 64'd35)
  };

  localparam int STAGES = 6;

endpackage

### src/srl_if.sv
// ----------------------------------------------------------------------------
// srl_in_if / srl_out_if
// Valid/ready channels for the sender resistance linearizer: one carries a
// reading word, the other a result word.
// ----------------------------------------------------------------------------
interface srl_in_if import srl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [OHMS_W-1:0] ohms;

  modport source (output valid, output command, output ohms, input ready);
  modport sink (input valid, input command, input ohms, output ready);
endinterface

interface srl_out_if import srl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_q8;
  logic               clamped;

  modport source (output valid, output value_q8, output clamped, input ready);
  modport sink (input valid, input value_q8, input clamped, output ready);
endinterface

### src/sender_resistance_linearizer_core.sv
// ----------------------------------------------------------------------------
// sender_resistance_linearizer_core
// Piecewise-linear conversion of sender resistance to oil pressure or oil
// temperature, with the segment division done by reciprocal multiply.
//
//   Channel  Dir  Word                      Handshake
//   sample   in   command, ohms             valid/ready
//   result   out  value_q8, clamped         valid/ready
//
// Each word passes six register stages: segment search, table lookup,
// numerator product, reciprocal multiply, back-multiply, then correction
// and output. One word is taken every cycle while no result stall reaches the input.
// A stalled result holds in the output register while empty stages upstream
// still fill. Synchronous reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module sender_resistance_linearizer_core import srl_pkg::*; (
  input logic       clk,
  input logic       rst,
  srl_in_if.sink    sample,
  srl_out_if.source result
);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  logic [CMD_W-1:0]  s0_cmd;
  logic [OHMS_W-1:0] s0_ohms;
  logic [SEG_W-1:0]  s0_seg;
  logic              s0_clamp;
  logic [BASE_W-1:0] s0_cbase;

  logic               s1_sub;
  logic [OFF_W-1:0]   s1_off;
  logic [SPAN_W-1:0]  s1_span;
  logic [DIV_W-1:0]   s1_div;
  logic [RECIP_W-1:0] s1_recip;
  logic [BASE_W-1:0]  s1_base;
  logic               s1_clamp;

  logic               s2_sub;
  logic [NUM_W-1:0]   s2_num;
  logic [DIV_W-1:0]   s2_div;
  logic [RECIP_W-1:0] s2_recip;
  logic [BASE_W-1:0]  s2_base;
  logic               s2_clamp;

  logic              s3_sub;
  logic [NUM_W-1:0]  s3_num;
  logic [Q_W-1:0]    s3_qest;
  logic [DIV_W-1:0]  s3_div;
  logic [BASE_W-1:0] s3_base;
  logic              s3_clamp;

  logic              s4_sub;
  logic [NUM_W-1:0]  s4_num;
  logic [QD_W-1:0]   s4_qd;
  logic [Q_W-1:0]    s4_qest;
  logic [DIV_W-1:0]  s4_div;
  logic [BASE_W-1:0] s4_base;
  logic              s4_clamp;

  logic [VALUE_W-1:0] out_value;
  logic               out_clamped;

  logic [SEG_W-1:0]   seg_next;
  logic               clamp_next;
  logic [BASE_W-1:0]  cbase_next;

  logic [TSEG_W-1:0]  tseg;
  logic [TSEG_W-1:0]  tseg_hi;
  logic               sub_next;
  logic [OFF_W-1:0]   off_next;
  logic [SPAN_W-1:0]  span_next;
  logic [DIV_W-1:0]   div_next;
  logic [RECIP_W-1:0] recip_next;
  logic [BASE_W-1:0]  base_next;

  logic [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]   rem;
  logic [Q_W-1:0]     q_fix;
  logic [BASE_W-1:0]  val;
  logic [EXT_W-1:0]   val_ext;

  // Stage enables: a stage loads when it is empty or its successor moves.
  always_comb begin
    en[STAGES-1] = ~vld[STAGES-1] | result.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign sample.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= sample.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Segment search and end-of-table clamping.
  always_comb begin
    seg_next   = '0;
    clamp_next = 1'b0;
    cbase_next = '0;
    if (sample.command == CMD_PRESSURE) begin
      for (int j = 1; j < PRESS_POINTS - 1; j++) begin
        seg_next = seg_next + SEG_W'(sample.ohms > PRESS_OHM[j]);
      end
      if (sample.ohms < PRESS_OHM[0]) begin
        clamp_next = 1'b1;
        cbase_next = '0;
      end else if (sample.ohms > PRESS_OHM[PRESS_POINTS-1]) begin
        clamp_next = 1'b1;
        cbase_next = BASE_W'(PRESS_POINTS - 1) << FRAC_BITS;
      end
    end else begin
      for (int j = 1; j < TEMP_POINTS - 1; j++) begin
        seg_next = seg_next + SEG_W'(TEMP_OHM[j] > sample.ohms);
      end
      if (sample.ohms > TEMP_OHM[0]) begin
        clamp_next = 1'b1;
        cbase_next = BASE_W'(TEMP_DEG[0]) << FRAC_BITS;
      end else if (sample.ohms < TEMP_OHM[TEMP_POINTS-1]) begin
        clamp_next = 1'b1;
        cbase_next = BASE_W'(TEMP_DEG[TEMP_POINTS-1]) << FRAC_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_cmd   <= sample.command;
      s0_ohms  <= sample.ohms;
      s0_seg   <= seg_next;
      s0_clamp <= clamp_next;
      s0_cbase <= cbase_next;
    end
  end

  // Table lookup: offset into the segment, degree span, divisor and base.
  always_comb begin
    tseg    = s0_seg[TSEG_W-1:0];
    tseg_hi = TSEG_W'(tseg + TSEG_W'(1));
    if (s0_cmd == CMD_PRESSURE) begin
      sub_next   = 1'b0;
      off_next   = OFF_W'(s0_ohms - PRESS_OHM[s0_seg]);
      span_next  = SPAN_W'(1);
      div_next   = PRESS_DIV[s0_seg];
      recip_next = PRESS_RECIP[s0_seg];
      base_next  = BASE_W'(s0_seg) << FRAC_BITS;
    end else begin
      sub_next   = 1'b1;
      off_next   = OFF_W'(s0_ohms - TEMP_OHM[tseg_hi]);
      span_next  = SPAN_W'(TEMP_DEG[tseg_hi] - TEMP_DEG[tseg]);
      div_next   = TEMP_DIV[tseg];
      recip_next = TEMP_RECIP[tseg];
      base_next  = BASE_W'(TEMP_DEG[tseg_hi]) << FRAC_BITS;
    end
    if (s0_clamp) begin
      off_next  = '0;
      span_next = '0;
      base_next = s0_cbase;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sub   <= sub_next;
      s1_off   <= off_next;
      s1_span  <= span_next;
      s1_div   <= div_next;
      s1_recip <= recip_next;
      s1_base  <= base_next;
      s1_clamp <= s0_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_sub   <= s1_sub;
      s2_num   <= NUM_W'(NUM_W'(s1_off) * NUM_W'(s1_span)) << FRAC_BITS;
      s2_div   <= s1_div;
      s2_recip <= s1_recip;
      s2_base  <= s1_base;
      s2_clamp <= s1_clamp;
    end
  end

  assign prod = PROD_W'(s2_num) * PROD_W'(s2_recip);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_sub   <= s2_sub;
      s3_num   <= s2_num;
      s3_qest  <= Q_W'(prod >> NUM_W);
      s3_div   <= s2_div;
      s3_base  <= s2_base;
      s3_clamp <= s2_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_sub   <= s3_sub;
      s4_num   <= s3_num;
      s4_qd    <= QD_W'(s3_qest) * QD_W'(s3_div);
      s4_qest  <= s3_qest;
      s4_div   <= s3_div;
      s4_base  <= s3_base;
      s4_clamp <= s3_clamp;
    end
  end

  // The estimate is the quotient or one below it; the remainder decides.
  always_comb begin
    rem     = NUM_W'(s4_num - NUM_W'(s4_qd));
    q_fix   = s4_qest + Q_W'(rem >= NUM_W'(s4_div));
    val     = s4_sub ? BASE_W'(s4_base - BASE_W'(q_fix)) : BASE_W'(s4_base + BASE_W'(q_fix));
    val_ext = EXT_W'(val);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_value   <= (val_ext > EXT_W'(VALUE_MAX)) ? VALUE_MAX : val_ext[VALUE_W-1:0];
      out_clamped <= s4_clamp;
    end
  end

  assign result.valid    = vld[STAGES-1];
  assign result.value_q8 = out_value;
  assign result.clamped  = out_clamped;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (&vld))
    else $error("Input held off while a pipeline stage was empty.");

  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> ((NUM_W+1)'(rem) < ((NUM_W+1)'(s4_div) << 1)))
    else $error("Quotient estimate was off by more than one.");

  a_clamp_zero_offset: assert property (@(posedge clk) disable iff (rst)
    vld[1] && s1_clamp |-> (s1_off == '0) && (s1_span == '0))
    else $error("Clamped word carried a nonzero segment offset.");

endmodule
